// ----- rtl/ps2c_pkg.sv -----
`default_nettype none
package ps2c_pkg;

	localparam int FIFO_DEPTH = 128;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int COUNT_BITS = 32;
	localparam int TABLE_LEN = 59;
	localparam int TBL_IDX_W = $clog2(TABLE_LEN);
	localparam int ESC_LEN = 4;
	localparam int ESC_IDX_W = $clog2(ESC_LEN);
	localparam int ESC_CNT_W = $clog2(ESC_LEN + 1);
	localparam int PADDR_W = 3;

	typedef enum logic [1:0] {
		OP_SCAN   = 2'd0,
		OP_INJECT = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} ps2c_op_t;

	localparam logic REG_CTRL_C = 1'b0;

	localparam logic [7:0] PREFIX_BYTE = 8'he0;
	localparam logic [6:0] KEY_LSHIFT = 7'h2a;
	localparam logic [6:0] KEY_RSHIFT = 7'h36;
	localparam logic [6:0] KEY_CTRL   = 7'h1d;
	localparam logic [6:0] KEY_C      = 7'h2e;
	localparam logic [6:0] KEY_D      = 7'h20;
	localparam logic [6:0] KEY_Z      = 7'h2c;
	localparam logic [6:0] KEY_UP     = 7'h48;
	localparam logic [6:0] KEY_DOWN   = 7'h50;
	localparam logic [6:0] KEY_LEFT   = 7'h4b;
	localparam logic [6:0] KEY_RIGHT  = 7'h4d;
	localparam logic [6:0] KEY_HOME   = 7'h47;
	localparam logic [6:0] KEY_END    = 7'h4f;
	localparam logic [6:0] KEY_DEL    = 7'h53;

	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_EOT   = 8'h04;
	localparam logic [7:0] CH_SUB   = 8'h1a;
	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_LBRKT = 8'h5b;
	localparam logic [7:0] CH_TILDE = 8'h7e;

	localparam logic [7:0] PLAIN_MAP [TABLE_LEN] = '{
		8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
		8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
		8'h00, 8'h20, 8'h00
	};

	localparam logic [7:0] SHIFT_MAP [TABLE_LEN] = '{
		8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
		8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
		8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
		8'h00, 8'h20, 8'h00
	};

	typedef struct packed {
		logic                 load;
		logic                 exec;
		logic                 push;
		logic                 capture;
		logic [ESC_IDX_W-1:0] idx;
	} ps2c_cmd_t;

	typedef struct packed {
		logic [ESC_CNT_W-1:0] n_chars;
	} ps2c_sts_t;

	typedef struct packed {
		logic        read_valid;
		logic [7:0]  read_value;
		logic [6:0]  buffered_count;
		logic [31:0] pushed_total;
		logic [31:0] dropped_total;
		logic [31:0] scan_total;
		logic [7:0]  last_scan;
		logic        interrupt_request;
	} ps2c_res_t;

endpackage
`default_nettype wire

// ----- rtl/ps2c_if.sv -----
`default_nettype none
interface ps2c_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] scan_byte;
	logic [7:0] inject_value;

	modport source(output valid, output opcode, output scan_byte, output inject_value,
		input ready);
	modport sink(input valid, input opcode, input scan_byte, input inject_value,
		output ready);
endinterface

interface ps2c_out_if;
	logic        valid;
	logic        ready;
	logic        read_valid;
	logic [7:0]  read_value;
	logic [6:0]  buffered_count;
	logic [31:0] pushed_total;
	logic [31:0] dropped_total;
	logic [31:0] scan_total;
	logic [7:0]  last_scan;
	logic        interrupt_request;

	modport source(output valid, output read_valid, output read_value,
		output buffered_count, output pushed_total, output dropped_total,
		output scan_total, output last_scan, output interrupt_request, input ready);
	modport sink(input valid, input read_valid, input read_value,
		input buffered_count, input pushed_total, input dropped_total,
		input scan_total, input last_scan, input interrupt_request, output ready);
endinterface
`default_nettype wire

// ----- rtl/ps2_scancode_to_char_fifo_top.sv -----
// sequence: an accepted item is loaded, decoded in the exec state, then offered to
// the fifo one character per cycle (0 to 4, escape keys give the most) through the
// single fifo write port, and its result is captured once the output is free; an
// output stall holds it there, and no new item is accepted until back in idle
// reset: arst_n clears pointers, flags, counters and handshake state at once;
// ctrl_c_signals resets to 1, fifo storage is not cleared
`default_nettype none
module ps2_scancode_to_char_fifo_top (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire [ps2c_pkg::PADDR_W-1:0]        paddr,
	input  wire [31:0]                         pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	ps2c_in_if.sink                            in_ch,
	ps2c_out_if.source                         out_ch
);
	import ps2c_pkg::*;

	logic      ctrl_c_q;
	ps2c_cmd_t cmd;
	ps2c_sts_t sts;
	ps2c_res_t res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CTRL_C) ? {31'b0, ctrl_c_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_c_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CTRL_C) begin
			ctrl_c_q <= pwdata[0];
		end
	end

	ps2c_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ps2c_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl_c_signals (ctrl_c_q),
		.opcode         (in_ch.opcode),
		.scan_byte      (in_ch.scan_byte),
		.inject_value   (in_ch.inject_value),
		.cmd            (cmd),
		.sts            (sts),
		.res            (res)
	);

	assign out_ch.read_valid = res.read_valid;
	assign out_ch.read_value = res.read_value;
	assign out_ch.buffered_count = res.buffered_count;
	assign out_ch.pushed_total = res.pushed_total;
	assign out_ch.dropped_total = res.dropped_total;
	assign out_ch.scan_total = res.scan_total;
	assign out_ch.last_scan = res.last_scan;
	assign out_ch.interrupt_request = res.interrupt_request;

`ifndef SYNTH
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("second transfer taken while an item is in work");

	a_capture_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> out_ch.valid)
		else $error("captured result not presented");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.exec, cmd.push, cmd.capture}))
		else $error("controller issued overlapping commands");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res))
		else $error("waiting result changed before its transfer");
`endif
endmodule
`default_nettype wire

// ----- rtl/ps2c_ctrl.sv -----
`default_nettype none
module ps2c_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  ps2c_pkg::ps2c_sts_t  sts,
	output ps2c_pkg::ps2c_cmd_t  cmd
);
	import ps2c_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PUSH,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [ESC_IDX_W-1:0] idx_q;
	logic [ESC_CNT_W-1:0] n_q;
	logic                 out_valid_q;
	logic                 last_push;

	assign last_push = ({1'b0, idx_q} == (n_q - ESC_CNT_W'(1)));

	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.exec = (state_q == ST_EXEC);
		cmd.push = (state_q == ST_PUSH);
		cmd.capture = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			n_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					n_q <= sts.n_chars;
					idx_q <= '0;
					state_q <= (sts.n_chars != '0) ? ST_PUSH : ST_DONE;
				end
				ST_PUSH: begin
					// one character per cycle through the single write port
					idx_q <= idx_q + ESC_IDX_W'(1);
					if (last_push)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/ps2c_dp.sv -----
`default_nettype none
module ps2c_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  ctrl_c_signals,
	input  wire [1:0]            opcode,
	input  wire [7:0]            scan_byte,
	input  wire [7:0]            inject_value,
	input  ps2c_pkg::ps2c_cmd_t  cmd,
	output ps2c_pkg::ps2c_sts_t  sts,
	output ps2c_pkg::ps2c_res_t  res
);
	import ps2c_pkg::*;

	logic [7:0]            mem [FIFO_DEPTH];
	logic [7:0]            mem_rd_q;

	ps2c_op_t              op_q;
	logic [7:0]            scan_q;
	logic [7:0]            inj_q;

	logic [PTR_W-1:0]      head_q;
	logic [PTR_W-1:0]      tail_q;
	logic                  shift_q;
	logic                  ctrl_q;
	logic                  prefix_q;
	logic [COUNT_BITS-1:0] push_cnt_q;
	logic [COUNT_BITS-1:0] drop_cnt_q;
	logic [COUNT_BITS-1:0] scan_cnt_q;
	logic [7:0]            last_scan_q;
	logic                  rv_q;
	logic                  irq_q;
	logic [7:0]            chars_q [ESC_LEN];
	ps2c_res_t             res_q;

	logic [6:0]            key;
	logic                  up;
	logic [7:0]            tbl_ch;
	logic [7:0]            dec_c [ESC_LEN];
	logic [ESC_CNT_W-1:0]  dec_n;
	logic                  dec_irq;
	logic                  full;
	logic                  empty;

	assign key = scan_q[6:0];
	assign up = scan_q[7];
	assign full = ((tail_q + PTR_W'(1)) == head_q);
	assign empty = (head_q == tail_q);

	always_comb begin
		dec_c = '{default: '0};
		dec_n = '0;
		dec_irq = 1'b0;
		tbl_ch = '0;
		if (key < 7'(TABLE_LEN))
			tbl_ch = shift_q ? SHIFT_MAP[key[TBL_IDX_W-1:0]] : PLAIN_MAP[key[TBL_IDX_W-1:0]];
		if (ctrl_q) begin
			if (key == KEY_C)
				tbl_ch = CH_ETX;
			else if (key == KEY_D)
				tbl_ch = CH_EOT;
			else if (key == KEY_Z)
				tbl_ch = CH_SUB;
		end
		case (op_q)
			OP_SCAN: begin
				if (scan_q == PREFIX_BYTE) begin
					dec_n = '0;
				end else if (prefix_q) begin
					// the extended key presses listed below become ansi escape sequences
					dec_c[0] = CH_ESC;
					dec_c[1] = CH_LBRKT;
					if (!up) begin
						case (key)
							KEY_UP:    begin dec_c[2] = 8'h41; dec_n = ESC_CNT_W'(3); end
							KEY_DOWN:  begin dec_c[2] = 8'h42; dec_n = ESC_CNT_W'(3); end
							KEY_LEFT:  begin dec_c[2] = 8'h44; dec_n = ESC_CNT_W'(3); end
							KEY_RIGHT: begin dec_c[2] = 8'h43; dec_n = ESC_CNT_W'(3); end
							KEY_HOME:  begin dec_c[2] = 8'h48; dec_n = ESC_CNT_W'(3); end
							KEY_END:   begin dec_c[2] = 8'h46; dec_n = ESC_CNT_W'(3); end
							KEY_DEL: begin
								dec_c[2] = 8'h33;
								dec_c[3] = CH_TILDE;
								dec_n = ESC_CNT_W'(4);
							end
							default: dec_n = '0;
						endcase
					end
				end else if (key == KEY_LSHIFT || key == KEY_RSHIFT || key == KEY_CTRL || up) begin
					dec_n = '0;
				end else if (tbl_ch == CH_ETX && ctrl_c_signals) begin
					dec_irq = 1'b1;
				end else if (tbl_ch != '0) begin
					dec_c[0] = tbl_ch;
					dec_n = ESC_CNT_W'(1);
				end
			end
			OP_INJECT: begin
				if (inj_q != '0) begin
					dec_c[0] = inj_q;
					dec_n = ESC_CNT_W'(1);
				end
			end
			default: dec_n = '0;
		endcase
	end

	assign sts.n_chars = dec_n;

	always_ff @(posedge clk) begin
		if (cmd.push && !full)
			mem[tail_q] <= chars_q[cmd.idx];
		if (cmd.exec)
			mem_rd_q <= mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= ps2c_op_t'(opcode);
			scan_q <= scan_byte;
			inj_q <= inject_value;
		end
		if (cmd.exec)
			chars_q <= dec_c;
		if (cmd.capture) begin
			res_q.read_valid <= rv_q;
			res_q.read_value <= rv_q ? mem_rd_q : 8'h00;
			res_q.buffered_count <= 7'(tail_q - head_q);
			res_q.pushed_total <= 32'(push_cnt_q);
			res_q.dropped_total <= 32'(drop_cnt_q);
			res_q.scan_total <= 32'(scan_cnt_q);
			res_q.last_scan <= last_scan_q;
			res_q.interrupt_request <= irq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			shift_q <= 1'b0;
			ctrl_q <= 1'b0;
			prefix_q <= 1'b0;
			push_cnt_q <= '0;
			drop_cnt_q <= '0;
			scan_cnt_q <= '0;
			last_scan_q <= '0;
			rv_q <= 1'b0;
			irq_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				irq_q <= dec_irq;
				rv_q <= (op_q == OP_READ) && !empty;
				case (op_q)
					OP_SCAN: begin
						scan_cnt_q <= scan_cnt_q + COUNT_BITS'(1);
						last_scan_q <= scan_q;
						if (scan_q == PREFIX_BYTE)
							prefix_q <= 1'b1;
						else if (prefix_q)
							prefix_q <= 1'b0;
						else if (key == KEY_LSHIFT || key == KEY_RSHIFT)
							shift_q <= !up;
						else if (key == KEY_CTRL)
							ctrl_q <= !up;
					end
					OP_READ: begin
						if (!empty)
							head_q <= head_q + PTR_W'(1);
					end
					default: ;
				endcase
			end
			if (cmd.push) begin
				// one slot stays free so full and empty differ
				if (full) begin
					drop_cnt_q <= drop_cnt_q + COUNT_BITS'(1);
				end else begin
					tail_q <= tail_q + PTR_W'(1);
					push_cnt_q <= push_cnt_q + COUNT_BITS'(1);
				end
			end
		end
	end

	assign res = res_q;
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import ps2c_pkg::*;

	localparam int MAX_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int KEYMAP_LEN = 59;
	localparam int CHUNK_ITEMS = 60;

	localparam logic [7:0] SC_PREFIX = 8'he0;
	localparam logic [6:0] SC_LSHIFT = 7'h2a;
	localparam logic [6:0] SC_RSHIFT = 7'h36;
	localparam logic [6:0] SC_CTRL = 7'h1d;
	localparam logic [6:0] SC_C = 7'h2e;
	localparam logic [6:0] SC_D = 7'h20;
	localparam logic [6:0] SC_Z = 7'h2c;
	localparam logic [6:0] SC_UP = 7'h48;
	localparam logic [6:0] SC_DOWN = 7'h50;
	localparam logic [6:0] SC_LEFT = 7'h4b;
	localparam logic [6:0] SC_RIGHT = 7'h4d;
	localparam logic [6:0] SC_HOME = 7'h47;
	localparam logic [6:0] SC_END = 7'h4f;
	localparam logic [6:0] SC_DEL = 7'h53;
	localparam logic [6:0] EXT_KEYS [7] = '{SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_HOME,
		SC_END, SC_DEL};

	localparam logic [7:0] PLAIN_KEYS [KEYMAP_LEN] = '{
		8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
		8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
		8'h00, 8'h20, 8'h00
	};

	localparam logic [7:0] SHIFT_KEYS [KEYMAP_LEN] = '{
		8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
		8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
		8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
		8'h00, 8'h20, 8'h00
	};

	typedef enum {FLOW_FILL, FLOW_MIX, FLOW_DRAIN} flow_t;

	typedef struct {
		ps2c_op_t   op;
		logic [7:0] scan;
		logic [7:0] inj;
	} key_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	ps2c_in_if in_ch();
	ps2c_out_if out_ch();

	ps2_scancode_to_char_fifo_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// shadow of the decoder and fifo state
	logic [7:0] char_mem [FIFO_DEPTH];
	logic [PTR_W-1:0] rd_ptr = '0;
	logic [PTR_W-1:0] wr_ptr = '0;
	logic shift_on = 1'b0;
	logic ctrl_on = 1'b0;
	logic ext_pending = 1'b0;
	logic [31:0] pushed_cnt = '0;
	logic [31:0] dropped_cnt = '0;
	logic [31:0] scan_cnt = '0;
	logic [7:0] last_byte = '0;
	logic ctrl_c_irq_cfg = 1'b1;

	key_item_t pending_items[$];
	ps2c_res_t status_due[$];
	ps2c_res_t due_status;
	key_item_t cur_item;

	int sent_cnt = 0;
	int acc_cnt = 0;
	int stim_cnt = 0;
	int mism_cnt = 0;
	int cycle_cnt = 0;
	int in_gap = 0;
	int out_stall = 0;
	bit calm_in = 1'b0;
	bit calm_out = 1'b0;
	int chunk_idx = -1;
	int next_switch = 0;
	flow_t flow = FLOW_FILL;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void offer_char(input logic [7:0] ch);
		logic [PTR_W-1:0] nxt;
		nxt = wr_ptr + 1'b1;
		// one slot stays free, so a full fifo drops the character
		if (nxt == rd_ptr) begin
			dropped_cnt++;
		end else begin
			char_mem[wr_ptr] = ch;
			wr_ptr = nxt;
			pushed_cnt++;
		end
	endfunction

	function automatic void offer_escape(input logic [7:0] fin1, input logic [7:0] fin2);
		offer_char(8'h1b);
		offer_char(8'h5b);
		offer_char(fin1);
		if (fin2 != 8'h00)
			offer_char(fin2);
	endfunction

	function automatic logic decode_scan(input logic [7:0] b);
		logic [6:0] key;
		logic [7:0] ch;
		key = b[6:0];
		ch = 8'h00;
		scan_cnt++;
		last_byte = b;
		if (b == SC_PREFIX) begin
			ext_pending = 1'b1;
			return 1'b0;
		end
		if (ext_pending) begin
			ext_pending = 1'b0;
			if (!b[7]) begin
				case (key)
				SC_UP: offer_escape(8'h41, 8'h00);
				SC_DOWN: offer_escape(8'h42, 8'h00);
				SC_LEFT: offer_escape(8'h44, 8'h00);
				SC_RIGHT: offer_escape(8'h43, 8'h00);
				SC_HOME: offer_escape(8'h48, 8'h00);
				SC_END: offer_escape(8'h46, 8'h00);
				SC_DEL: offer_escape(8'h33, 8'h7e);
				default: ;
				endcase
			end
			return 1'b0;
		end
		if (key == SC_LSHIFT || key == SC_RSHIFT) begin
			shift_on = !b[7];
			return 1'b0;
		end
		if (key == SC_CTRL) begin
			ctrl_on = !b[7];
			return 1'b0;
		end
		if (b[7])
			return 1'b0;
		if (key < KEYMAP_LEN)
			ch = shift_on ? SHIFT_KEYS[key] : PLAIN_KEYS[key];
		if (ctrl_on && (key == SC_C || key == SC_D || key == SC_Z))
			ch = (key == SC_C) ? 8'h03 : ((key == SC_D) ? 8'h04 : 8'h1a);
		if (ch == 8'h03 && ctrl_c_irq_cfg)
			return 1'b1;
		if (ch != 8'h00)
			offer_char(ch);
		return 1'b0;
	endfunction

	function automatic ps2c_res_t predict_status(input ps2c_op_t op, input logic [7:0] scan,
		input logic [7:0] inj);
		ps2c_res_t r;
		r = '0;
		case (op)
		OP_SCAN: r.interrupt_request = decode_scan(scan);
		OP_INJECT: begin
			if (inj != 8'h00)
				offer_char(inj);
		end
		OP_READ: begin
			if (rd_ptr != wr_ptr) begin
				r.read_valid = 1'b1;
				r.read_value = char_mem[rd_ptr];
				rd_ptr = rd_ptr + 1'b1;
			end
		end
		default: ;
		endcase
		r.buffered_count = 7'(wr_ptr - rd_ptr);
		r.pushed_total = pushed_cnt;
		r.dropped_total = dropped_cnt;
		r.scan_total = scan_cnt;
		r.last_scan = last_byte;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (got_v !== want_v) begin
			mism_cnt++;
			if (mism_cnt <= 10)
				$display("mismatch on %s: expected %0h, got %0h", name, want_v, got_v);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(16, 60);
	endfunction

	// results and accepted items, both seen at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_cnt++;
			if (cycle_cnt > MAX_CYCLES) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				if (out_ch.valid && out_ch.ready) begin
					if (status_due.size() == 0) begin
						mism_cnt++;
						if (mism_cnt <= 10)
							$display("result transfer with nothing expected, count %0d",
								out_ch.buffered_count);
					end else begin
						due_status = status_due.pop_front();
						check_field("read_valid", due_status.read_valid, out_ch.read_valid);
						check_field("read_value", due_status.read_value, out_ch.read_value);
						check_field("buffered_count", due_status.buffered_count,
							out_ch.buffered_count);
						check_field("pushed_total", due_status.pushed_total,
							out_ch.pushed_total);
						check_field("dropped_total", due_status.dropped_total,
							out_ch.dropped_total);
						check_field("scan_total", due_status.scan_total, out_ch.scan_total);
						check_field("last_scan", due_status.last_scan, out_ch.last_scan);
						check_field("interrupt_request", due_status.interrupt_request,
							out_ch.interrupt_request);
					end
				end
				if (in_ch.valid && in_ch.ready) begin
					status_due.push_back(predict_status(ps2c_op_t'(in_ch.opcode),
						in_ch.scan_byte, in_ch.inject_value));
					acc_cnt++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || acc_cnt == sent_cnt) begin
			if (in_gap > 0) begin
				in_ch.valid <= 1'b0;
				in_gap--;
			end else if (pending_items.size() != 0) begin
				cur_item = pending_items.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.opcode <= cur_item.op;
				in_ch.scan_byte <= cur_item.scan;
				in_ch.inject_value <= cur_item.inj;
				sent_cnt++;
				in_gap = calm_in ? 0 : pick_gap();
			end else begin
				in_ch.valid <= 1'b0;
			end
			if ($urandom_range(0, 299) == 0)
				calm_in = !calm_in;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (out_stall > 0) begin
			out_ch.ready <= 1'b0;
			out_stall--;
		end else if (!calm_out && $urandom_range(0, 4) == 0) begin
			out_ch.ready <= 1'b0;
			out_stall = pick_gap();
		end else begin
			out_ch.ready <= 1'b1;
		end
		if ($urandom_range(0, 299) == 0)
			calm_out = !calm_out;
	end

	task automatic add_item(input ps2c_op_t op, input logic [7:0] scan, input logic [7:0] inj);
		key_item_t it;
		it.op = op;
		it.scan = (op == OP_SCAN) ? scan : 8'($urandom);
		it.inj = (op == OP_INJECT) ? inj : 8'($urandom);
		pending_items.push_back(it);
		if (op != OP_NONE && !(op == OP_INJECT && inj == 8'h00))
			stim_cnt++;
	endtask

	task automatic add_scan(input logic [7:0] b);
		add_item(OP_SCAN, b, 8'h00);
	endtask

	function automatic logic [6:0] pick_key();
		if ($urandom_range(0, 4) == 0)
			return 7'($urandom_range(0, 127));
		return 7'($urandom_range(0, KEYMAP_LEN - 1));
	endfunction

	task automatic add_keystroke();
		int r;
		int read_pct;
		logic [6:0] key;
		logic [6:0] mod;
		case (flow)
		FLOW_FILL: read_pct = 0;
		FLOW_DRAIN: read_pct = 70;
		default: read_pct = 25;
		endcase
		if ($urandom_range(0, 99) < read_pct) begin
			add_item(OP_READ, 8'h00, 8'h00);
			return;
		end
		// filling leans on escape keys and injected characters
		r = $urandom_range(flow == FLOW_FILL ? 50 : 0, 99);
		key = pick_key();
		if (r < 22) begin
			add_scan({1'b0, key});
			add_scan({1'b1, key});
		end else if (r < 36) begin
			mod = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
			add_scan({1'b0, mod});
			add_scan({1'b0, key});
			add_scan({1'b1, key});
			add_scan({1'b1, mod});
		end else if (r < 48) begin
			case ($urandom_range(0, 3))
			0: key = SC_C;
			1: key = SC_D;
			2: key = SC_Z;
			default: ;
			endcase
			add_scan({1'b0, SC_CTRL});
			add_scan({1'b0, key});
			add_scan({1'b1, key});
			add_scan({1'b1, SC_CTRL});
		end else if (r < 66) begin
			if ($urandom_range(0, 5) != 0)
				key = EXT_KEYS[$urandom_range(0, 6)];
			add_scan(SC_PREFIX);
			add_scan({1'b0, key});
			add_scan(SC_PREFIX);
			add_scan({1'b1, key});
		end else if (r < 84) begin
			add_item(OP_INJECT, 8'h00,
				($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
		end else if (r < 95) begin
			// stray byte, may break a sequence or leave a modifier stuck
			add_scan(8'($urandom));
		end else begin
			add_item(OP_NONE, 8'h00, 8'h00);
		end
	endtask

	task automatic run_random(input int n);
		int stop_at;
		stop_at = stim_cnt + n;
		while (stim_cnt < stop_at) begin
			if (stim_cnt >= next_switch) begin
				chunk_idx = (chunk_idx + 1) % 7;
				flow = (chunk_idx < 3) ? FLOW_FILL : ((chunk_idx == 3) ? FLOW_MIX : FLOW_DRAIN);
				next_switch = stim_cnt + CHUNK_ITEMS;
			end
			add_keystroke();
		end
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || sent_cnt != acc_cnt || status_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_ctrl_c(input logic val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = PADDR_W'(4 * REG_CTRL_C);
		pwdata = $urandom;
		pwdata[0] = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		ctrl_c_irq_cfg = val;
	endtask

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_NONE;
		in_ch.scan_byte = 8'h00;
		in_ch.inject_value = 8'h00;
		out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_item(OP_READ, 8'h00, 8'h00);
		add_item(OP_NONE, 8'hff, 8'hff);
		add_item(OP_INJECT, 8'h00, 8'h00);
		add_item(OP_INJECT, 8'h00, 8'hff);
		add_item(OP_INJECT, 8'h00, 8'h01);
		add_scan(8'h1e);
		add_scan(8'h9e);
		add_scan({1'b0, SC_LSHIFT});
		add_scan(8'h10);
		add_scan({1'b1, SC_LSHIFT});
		// ctrl-c raises the interrupt while the register is at its reset value
		add_scan({1'b0, SC_CTRL});
		add_scan({1'b0, SC_C});
		add_scan({1'b0, SC_D});
		add_scan({1'b0, SC_Z});
		add_scan({1'b1, SC_CTRL});
		add_scan(SC_PREFIX);
		add_scan({1'b0, SC_DEL});
		add_scan(SC_PREFIX);
		add_scan({1'b1, SC_DEL});
		add_scan(SC_PREFIX);
		add_scan({1'b0, SC_RSHIFT});
		add_scan(8'h7f);
		add_scan(8'h00);
		add_scan(8'hff);
		add_item(OP_READ, 8'h00, 8'h00);
		wait_idle();

		write_ctrl_c(1'b0);
		add_scan({1'b0, SC_CTRL});
		add_scan({1'b0, SC_C});
		add_scan({1'b1, SC_C});
		add_scan({1'b1, SC_CTRL});
		run_random(200);
		wait_idle();
		run_random(130);
		wait_idle();

		write_ctrl_c(1'b1);
		run_random(200);
		wait_idle();

		write_ctrl_c(1'b0);
		run_random(120);
		wait_idle();

		if (mism_cnt == 0 && status_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
